@@ hw/rtl/smx_pkg.sv @@
`timescale 1ns / 1ps

package smx_pkg;

    localparam int SLEW_W        = 16;
    localparam int CODE_W        = 4;
    localparam int MAP_POSITIONS = 8;
    localparam int POS_W         = 3;
    localparam int COUNT_W       = 4;
    localparam int MAP_W         = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int SET_W         = 3;
    localparam int CHAN_W        = 3;
    localparam int KIND_W        = 2;

    // speaker code that marks an unused map position
    localparam logic [CODE_W-1:0]  CODE_UNKNOWN        = 4'hF;
    // channel sets up to and including 7.1 restore the stereo pass-through
    localparam logic [SET_W-1:0]   SET_LAST_DEFAULT    = 3'd3;
    localparam logic [COUNT_W-1:0] RESET_CHANNEL_COUNT = 4'd2;
    localparam logic [MAP_W-1:0]   RESET_CHANNEL_MAP   = 32'h0000_0010;

    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME,
        KIND_STAGE,
        KIND_COMMIT,
        KIND_RESTORE
    } kind_t;

    typedef enum logic {
        CFG_CHANNEL_COUNT,
        CFG_CHANNEL_MAP
    } cfg_index_t;

    typedef enum logic [2:0] {
        BANK_NONE,
        BANK_STAGE,
        BANK_COMMIT,
        BANK_RESTORE,
        BANK_ADVANCE
    } bank_op_t;

    typedef struct packed {
        bank_op_t            op;
        logic [CHAN_W-1:0]   channel;
        logic                side;
        logic [SLEW_W-1:0]   frames;
        logic [SET_W-1:0]    chan_set;
    } bank_cmd_t;

    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_SLEW_MUL,
        MAC_DIV_INIT,
        MAC_DIV_STEP,
        MAC_BLEND,
        MAC_MUL,
        MAC_ACC
    } mac_op_t;

    typedef struct packed {
        mac_op_t op;
        logic    first;
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_SLEW_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_BLEND,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

endpackage

@@ hw/rtl/stereo_matrix_mixer_with_slew_top.sv @@
`timescale 1ns / 1ps

// stereo to multichannel mixing matrix with coefficient crossfade
// in channel (in_valid/in_ready): one transaction per item; kind selects a
//   frame, a coefficient stage, a commit with slew length, or a default restore
// out channel (out_valid/out_ready): one transaction per mixed map position,
//   in position order, last marks the final one of a frame
// cfg channel (cfg_valid/cfg_ready): always ready, cfg_index 0 channel count,
//   1 channel map; write only while the block is idle
// non-frame items leave the block idle; a frame scans the positions in order,
//   skipping those not mixed, and runs load, multiply and accumulate for the left
//   then the right term of each mixed one, with a slew multiply and a divide ahead of
//   the multiply while a slew runs; the pace is set by the single shared multiplier
//   and the one bit per cycle divider that blends each coefficient
// in_ready is low while a frame is mixed; the last result of a frame may still
//   sit in the output register while the next item is taken
// when the receiver stalls, the mix waits with the next result held until the
//   output register frees up
// reset restores the stereo pass-through bank, clears the staged and previous
//   banks and the slew, and loads channel count 2 with map front left/right
module stereo_matrix_mixer_with_slew_top #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    parameter int COEF_BITS    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [smx_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [smx_pkg::KIND_W-1:0]            kind,
    input  logic signed [SAMPLE_BITS-1:0]         left_sample,
    input  logic signed [SAMPLE_BITS-1:0]         right_sample,
    input  logic [smx_pkg::CHAN_W-1:0]            coef_channel,
    input  logic                                  coef_side,
    input  logic signed [COEF_BITS-1:0]           coef_value,
    input  logic [smx_pkg::SLEW_W-1:0]            slew_frames,
    input  logic [smx_pkg::SET_W-1:0]             channel_set,
    // results
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [smx_pkg::POS_W-1:0]             position,
    output logic signed [SAMPLE_BITS-1:0]         contribution,
    output logic                                  clipped,
    output logic                                  last
);

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int IDX_W     = CH_W + 1;
    localparam int DIV_CNT_W = $clog2(COEF_BITS);
    localparam int NPOS      = smx_pkg::MAP_POSITIONS;
    localparam int CODE_W    = smx_pkg::CODE_W;

    smx_pkg::state_t                 state_reg, state_next;
    logic [smx_pkg::POS_W-1:0]       pos_idx_reg;
    logic                            side_reg;
    logic [NPOS-1:0]                 mask_reg;      // positions still to be mixed
    logic                            slewing_reg;
    logic [DIV_CNT_W-1:0]            div_cnt_reg;
    logic [smx_pkg::COUNT_W-1:0]     count_reg;
    logic [smx_pkg::MAP_W-1:0]       map_reg;
    logic                            out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   left_reg;
    logic signed [SAMPLE_BITS-1:0]   right_reg;
    logic [smx_pkg::POS_W-1:0]       position_reg;
    logic signed [SAMPLE_BITS-1:0]   contribution_reg;
    logic                            clipped_reg;
    logic                            last_reg;

    smx_pkg::bank_cmd_t              bank_cmd;
    smx_pkg::mac_ctrl_t              mac_ctrl;
    logic [IDX_W-1:0]                rd_idx;
    logic [CODE_W-1:0]               cur_code;
    logic signed [COEF_BITS-1:0]     cur_coef;
    logic signed [COEF_BITS-1:0]     prev_coef;
    logic [smx_pkg::SLEW_W-1:0]      slew_pos;
    logic [smx_pkg::SLEW_W-1:0]      slew_len;
    logic signed [SAMPLE_BITS-1:0]   mix;
    logic                            mix_clip;
    logic [NPOS-1:0]                 frame_mask;
    logic [NPOS-1:0]                 mask_rest;
    logic                            slew_active;
    logic                            in_fire;
    logic                            cfg_fire;
    logic                            frame_fire;
    logic                            emit_load;

    assign in_ready   = (state_reg == smx_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_fire    = in_valid && in_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign frame_fire = in_fire && (smx_pkg::kind_t'(kind) == smx_pkg::KIND_FRAME);

    // a slew is running while the position has not reached a nonzero length
    assign slew_active = (slew_len != '0) && (slew_pos < slew_len);

    // positions that produce a result: inside the count, known and existing speaker
    always_comb
    begin
        for (int p = 0; p < NPOS; p++)
        begin
            frame_mask[p] = (smx_pkg::COUNT_W'(p) < count_reg)
                && (map_reg[p*CODE_W +: CODE_W] != smx_pkg::CODE_UNKNOWN)
                && (int'(map_reg[p*CODE_W +: CODE_W]) < NUM_CHANNELS);
        end
    end

    assign cur_code  = map_reg[pos_idx_reg*CODE_W +: CODE_W];
    assign rd_idx    = {cur_code[CH_W-1:0], side_reg};
    assign mask_rest = mask_reg & ~(NPOS'(1) << pos_idx_reg);
    assign emit_load = (state_reg == smx_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    smx_coef_bank #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COEF_BITS    (COEF_BITS)
    ) u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (bank_cmd),
        .coef_value (coef_value),
        .rd_idx     (rd_idx),
        .cur_coef   (cur_coef),
        .prev_coef  (prev_coef),
        .slew_pos   (slew_pos),
        .slew_len   (slew_len)
    );

    smx_mac_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk       (clk),
        .ctrl      (mac_ctrl),
        .sample    (side_reg ? right_reg : left_reg),
        .cur_coef  (cur_coef),
        .prev_coef (prev_coef),
        .slew_pos  (slew_pos),
        .slew_len  (slew_len),
        .mix_out   (mix),
        .clip_out  (mix_clip)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer: per position, left term then right term, each with an
    // optional blend through the divider
    always_comb
    begin
        state_next        = state_reg;
        bank_cmd.op       = smx_pkg::BANK_NONE;
        bank_cmd.channel  = coef_channel;
        bank_cmd.side     = coef_side;
        bank_cmd.frames   = slew_frames;
        bank_cmd.chan_set = channel_set;
        mac_ctrl.op       = smx_pkg::MAC_HOLD;
        mac_ctrl.first    = !side_reg;
        unique case (state_reg)
            smx_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (smx_pkg::kind_t'(kind))
                        smx_pkg::KIND_FRAME:   state_next  = smx_pkg::ST_SCAN;
                        smx_pkg::KIND_STAGE:   bank_cmd.op = smx_pkg::BANK_STAGE;
                        smx_pkg::KIND_COMMIT:  bank_cmd.op = smx_pkg::BANK_COMMIT;
                        smx_pkg::KIND_RESTORE: bank_cmd.op = smx_pkg::BANK_RESTORE;
                    endcase
                end
            end
            smx_pkg::ST_SCAN:
            begin
                if (mask_reg == '0)
                begin
                    // frame done, the slew advances even when nothing was mixed
                    if (slewing_reg)
                    begin
                        bank_cmd.op = smx_pkg::BANK_ADVANCE;
                    end
                    state_next = smx_pkg::ST_IDLE;
                end
                else if (mask_reg[pos_idx_reg])
                begin
                    state_next = smx_pkg::ST_LOAD;
                end
            end
            smx_pkg::ST_LOAD:
            begin
                mac_ctrl.op = smx_pkg::MAC_LOAD;
                state_next  = slewing_reg ? smx_pkg::ST_SLEW_MUL : smx_pkg::ST_MUL;
            end
            smx_pkg::ST_SLEW_MUL:
            begin
                mac_ctrl.op = smx_pkg::MAC_SLEW_MUL;
                state_next  = smx_pkg::ST_DIV_INIT;
            end
            smx_pkg::ST_DIV_INIT:
            begin
                mac_ctrl.op = smx_pkg::MAC_DIV_INIT;
                state_next  = smx_pkg::ST_DIV;
            end
            smx_pkg::ST_DIV:
            begin
                mac_ctrl.op = smx_pkg::MAC_DIV_STEP;
                if (div_cnt_reg == '0)
                begin
                    state_next = smx_pkg::ST_BLEND;
                end
            end
            smx_pkg::ST_BLEND:
            begin
                mac_ctrl.op = smx_pkg::MAC_BLEND;
                state_next  = smx_pkg::ST_MUL;
            end
            smx_pkg::ST_MUL:
            begin
                mac_ctrl.op = smx_pkg::MAC_MUL;
                state_next  = smx_pkg::ST_ACC;
            end
            smx_pkg::ST_ACC:
            begin
                mac_ctrl.op = smx_pkg::MAC_ACC;
                state_next  = side_reg ? smx_pkg::ST_EMIT : smx_pkg::ST_LOAD;
            end
            smx_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = smx_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = smx_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer counters, registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_idx_reg   <= '0;
            side_reg      <= 1'b0;
            mask_reg      <= '0;
            slewing_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            count_reg     <= smx_pkg::RESET_CHANNEL_COUNT;
            map_reg       <= smx_pkg::RESET_CHANNEL_MAP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_fire)
            begin
                mask_reg    <= frame_mask;
                pos_idx_reg <= '0;
                slewing_reg <= slew_active;
            end
            if (state_reg == smx_pkg::ST_SCAN && mask_reg != '0)
            begin
                if (mask_reg[pos_idx_reg])
                begin
                    side_reg <= 1'b0;
                end
                else
                begin
                    pos_idx_reg <= pos_idx_reg + 1'b1;
                end
            end
            if (state_reg == smx_pkg::ST_DIV_INIT)
            begin
                div_cnt_reg <= DIV_CNT_W'(COEF_BITS - 1);
            end
            else if (state_reg == smx_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (state_reg == smx_pkg::ST_ACC && !side_reg)
            begin
                side_reg <= 1'b1;
            end
            if (emit_load)
            begin
                mask_reg    <= mask_rest;
                pos_idx_reg <= pos_idx_reg + 1'b1;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_fire)
            begin
                unique case (smx_pkg::cfg_index_t'(cfg_index))
                    smx_pkg::CFG_CHANNEL_COUNT: count_reg <= cfg_data[smx_pkg::COUNT_W-1:0];
                    smx_pkg::CFG_CHANNEL_MAP:   map_reg   <= cfg_data[smx_pkg::MAP_W-1:0];
                endcase
            end
        end
    end

    // sample and result payload
    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
        if (emit_load)
        begin
            position_reg     <= pos_idx_reg;
            contribution_reg <= mix;
            clipped_reg      <= mix_clip;
            last_reg         <= (mask_rest == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = position_reg;
    assign contribution = contribution_reg;
    assign clipped      = clipped_reg;
    assign last         = last_reg;

    // nothing left to mix once the block is back to idle
    a_idle_mask_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smx_pkg::ST_IDLE |-> mask_reg == '0)
        else $error("pending positions while idle");

    // the divider only runs with a slew of nonzero length
    a_div_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smx_pkg::ST_DIV_INIT |-> (slewing_reg && slew_len != '0))
        else $error("blend started without a running slew");

    // a slewed frame moves the slew position by exactly one at its end
    a_slew_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smx_pkg::ST_SCAN && mask_reg == '0 && slewing_reg)
        |=> slew_pos == $past(slew_pos) + 1'b1)
        else $error("slew position did not advance");

    // a result flagged last leaves no position pending
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && mask_rest == '0) |=> (out_valid && last && state_reg == smx_pkg::ST_SCAN))
        else $error("last result without end of frame");

endmodule

@@ hw/rtl/smx_coef_bank.sv @@
`timescale 1ns / 1ps

module smx_coef_bank #(
    parameter int NUM_CHANNELS = 8,
    parameter int COEF_BITS    = 16,
    localparam int BANK_SIZE   = 2 * NUM_CHANNELS,
    localparam int CH_W        = $clog2(NUM_CHANNELS),
    localparam int IDX_W       = CH_W + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smx_pkg::bank_cmd_t                 cmd,
    input  logic signed [COEF_BITS-1:0]        coef_value,
    input  logic        [IDX_W-1:0]            rd_idx,
    output logic signed [COEF_BITS-1:0]        cur_coef,
    output logic signed [COEF_BITS-1:0]        prev_coef,
    output logic        [smx_pkg::SLEW_W-1:0]  slew_pos,
    output logic        [smx_pkg::SLEW_W-1:0]  slew_len
);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) <<< (COEF_BITS - 2);

    logic signed [COEF_BITS-1:0]       cur_bank_reg  [BANK_SIZE];
    logic signed [COEF_BITS-1:0]       prev_bank_reg [BANK_SIZE];
    logic signed [COEF_BITS-1:0]       stg_bank_reg  [BANK_SIZE];
    logic        [smx_pkg::SLEW_W-1:0] slew_pos_reg;
    logic        [smx_pkg::SLEW_W-1:0] slew_len_reg;
    logic        [IDX_W-1:0]           stg_idx;
    logic                              stg_ok;
    logic                              restore_on;

    assign stg_idx    = {cmd.channel[CH_W-1:0], cmd.side};
    assign stg_ok     = int'(cmd.channel) < NUM_CHANNELS;
    assign restore_on = cmd.chan_set <= smx_pkg::SET_LAST_DEFAULT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANK_SIZE; i++)
            begin
                cur_bank_reg[i]  <= (i == 0 || i == 3) ? COEF_ONE : '0;
                prev_bank_reg[i] <= '0;
                stg_bank_reg[i]  <= '0;
            end
            slew_pos_reg <= '0;
            slew_len_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                smx_pkg::BANK_NONE:
                begin
                end
                smx_pkg::BANK_STAGE:
                begin
                    if (stg_ok)
                    begin
                        stg_bank_reg[stg_idx] <= coef_value;
                    end
                end
                smx_pkg::BANK_COMMIT:
                begin
                    for (int i = 0; i < BANK_SIZE; i++)
                    begin
                        prev_bank_reg[i] <= cur_bank_reg[i];
                        cur_bank_reg[i]  <= stg_bank_reg[i];
                    end
                    slew_len_reg <= cmd.frames;
                    slew_pos_reg <= '0;
                end
                smx_pkg::BANK_RESTORE:
                begin
                    for (int i = 0; i < BANK_SIZE; i++)
                    begin
                        cur_bank_reg[i] <= (restore_on && (i == 0 || i == 3)) ? COEF_ONE : '0;
                    end
                    slew_len_reg <= '0;
                    slew_pos_reg <= '0;
                end
                smx_pkg::BANK_ADVANCE:
                begin
                    slew_pos_reg <= slew_pos_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cur_coef  = cur_bank_reg[rd_idx];
    assign prev_coef = prev_bank_reg[rd_idx];
    assign slew_pos  = slew_pos_reg;
    assign slew_len  = slew_len_reg;

endmodule

@@ hw/rtl/smx_mac_unit.sv @@
`timescale 1ns / 1ps

module smx_mac_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16,
    localparam int SLEW_W     = smx_pkg::SLEW_W,
    localparam int DIFF_W     = COEF_BITS + 1,
    localparam int MUL_A_W    = (SAMPLE_BITS > DIFF_W) ? SAMPLE_BITS : DIFF_W,
    localparam int MUL_B_W    = (COEF_BITS > SLEW_W + 1) ? COEF_BITS : SLEW_W + 1,
    localparam int PROD_W     = MUL_A_W + MUL_B_W,
    localparam int REM_W      = PROD_W + 2,
    localparam int ACC_W      = SAMPLE_BITS + COEF_BITS + 1,
    localparam int FRAC_BITS  = COEF_BITS - 2
) (
    input  logic                        clk,
    input  smx_pkg::mac_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [COEF_BITS-1:0] cur_coef,
    input  logic signed [COEF_BITS-1:0] prev_coef,
    input  logic        [SLEW_W-1:0]    slew_pos,
    input  logic        [SLEW_W-1:0]    slew_len,
    output logic signed [SAMPLE_BITS-1:0] mix_out,
    output logic                        clip_out
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

    logic signed [COEF_BITS-1:0] coef_reg;
    logic signed [COEF_BITS-1:0] prev_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic        [REM_W-1:0]     rem_reg;
    logic        [REM_W-1:0]     den_reg;
    logic        [COEF_BITS-1:0] quo_reg;
    logic                        neg_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [REM_W-1:0]     num;
    logic signed [DIFF_W-1:0]    quo_s;
    logic signed [DIFF_W-1:0]    quo_v;
    logic signed [DIFF_W-1:0]    blend_sum;
    logic signed [ACC_W-1:0]     rnd;
    logic signed [ACC_W-1:0]     scaled;

    // one multiplier serves both the slew ramp and the sample products
    always_comb
    begin
        if (ctrl.op == smx_pkg::MAC_SLEW_MUL)
        begin
            mul_a = MUL_A_W'(diff_reg);
            mul_b = MUL_B_W'($signed({1'b0, slew_pos}));
        end
        else
        begin
            mul_a = MUL_A_W'(sample);
            mul_b = MUL_B_W'(coef_reg);
        end
    end

    assign mul_p = mul_a * mul_b;

    // 2*(cur-prev)*pos + len, folded to a non-negative dividend
    assign num       = (REM_W'(prod_reg) <<< 1) + REM_W'($signed({1'b0, slew_len}));
    assign quo_s     = $signed({1'b0, quo_reg});
    assign quo_v     = neg_reg ? ~quo_s : quo_s;
    assign blend_sum = DIFF_W'(prev_reg) + quo_v;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            smx_pkg::MAC_LOAD:
            begin
                coef_reg <= cur_coef;
                prev_reg <= prev_coef;
                diff_reg <= DIFF_W'(cur_coef) - DIFF_W'(prev_coef);
            end
            smx_pkg::MAC_SLEW_MUL, smx_pkg::MAC_MUL:
            begin
                prod_reg <= mul_p;
            end
            smx_pkg::MAC_DIV_INIT:
            begin
                neg_reg <= num[REM_W-1];
                rem_reg <= num[REM_W-1] ? ~num : num;
                den_reg <= REM_W'({slew_len, 1'b0}) << (COEF_BITS - 1);
                quo_reg <= '0;
            end
            smx_pkg::MAC_DIV_STEP:
            begin
                if (rem_reg >= den_reg)
                begin
                    rem_reg <= rem_reg - den_reg;
                    quo_reg <= {quo_reg[COEF_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[COEF_BITS-2:0], 1'b0};
                end
                den_reg <= den_reg >> 1;
            end
            smx_pkg::MAC_BLEND:
            begin
                coef_reg <= blend_sum[COEF_BITS-1:0];
            end
            smx_pkg::MAC_ACC:
            begin
                acc_reg <= (ctrl.first ? '0 : acc_reg) + ACC_W'(prod_reg);
            end
            default:
            begin
            end
        endcase
    end

    // round half up, then saturate to the sample range
    assign rnd    = acc_reg + HALF;
    assign scaled = rnd >>> FRAC_BITS;

    always_comb
    begin
        clip_out = 1'b0;
        mix_out  = scaled[SAMPLE_BITS-1:0];
        if (scaled > SMAX)
        begin
            clip_out = 1'b1;
            mix_out  = SMAX[SAMPLE_BITS-1:0];
        end
        else if (scaled < SMIN)
        begin
            clip_out = 1'b1;
            mix_out  = SMIN[SAMPLE_BITS-1:0];
        end
    end

endmodule

@@ sim/tb_stereo_matrix_mixer_with_slew_top.sv @@
`timescale 1ns / 1ps

localparam int MIX_CHANNELS    = 8;
localparam int MIX_SAMPLE_BITS = 24;
localparam int MIX_COEF_BITS   = 16;
localparam int MIX_BANK        = 2 * MIX_CHANNELS;
localparam int MIX_FRAC        = MIX_COEF_BITS - 2;

typedef struct {
    smx_pkg::kind_t                    kind;
    logic signed [MIX_SAMPLE_BITS-1:0] l_smp;
    logic signed [MIX_SAMPLE_BITS-1:0] r_smp;
    logic [smx_pkg::CHAN_W-1:0]        coef_ch;
    logic                              coef_sd;
    logic signed [MIX_COEF_BITS-1:0]   coef_val;
    logic [smx_pkg::SLEW_W-1:0]        slew_len;
    logic [smx_pkg::SET_W-1:0]         chan_set;
} mix_item_t;

typedef struct {
    logic [smx_pkg::POS_W-1:0]         position;
    logic signed [MIX_SAMPLE_BITS-1:0] contribution;
    logic                              clipped;
    logic                              last;
} mix_result_t;

class mix_scoreboard;
    logic signed [MIX_COEF_BITS-1:0] cur_coefs[MIX_BANK];
    logic signed [MIX_COEF_BITS-1:0] prev_coefs[MIX_BANK];
    logic signed [MIX_COEF_BITS-1:0] staged_coefs[MIX_BANK];
    logic [smx_pkg::SLEW_W-1:0]      slew_pos;
    logic [smx_pkg::SLEW_W-1:0]      slew_total;
    logic [smx_pkg::COUNT_W-1:0]     chan_count;
    logic [smx_pkg::MAP_W-1:0]       chan_map;
    mix_result_t                     expected_mixes[$];
    int                              errors;

    function void reset_state();
        for (int i = 0; i < MIX_BANK; i++)
        begin
            cur_coefs[i]    = '0;
            prev_coefs[i]   = '0;
            staged_coefs[i] = '0;
        end
        cur_coefs[0] = MIX_COEF_BITS'(1 << MIX_FRAC);
        cur_coefs[3] = MIX_COEF_BITS'(1 << MIX_FRAC);
        slew_pos     = '0;
        slew_total   = '0;
        chan_count   = smx_pkg::RESET_CHANNEL_COUNT;
        chan_map     = smx_pkg::RESET_CHANNEL_MAP;
        errors       = 0;
    endfunction

    function void write_reg(smx_pkg::cfg_index_t idx, logic [smx_pkg::CFG_DATA_W-1:0] data);
        if (idx == smx_pkg::CFG_CHANNEL_COUNT)
            chan_count = data[smx_pkg::COUNT_W-1:0];
        else
            chan_map = data[smx_pkg::MAP_W-1:0];
    endfunction

    // linear crossfade, rounded half up
    function longint blend_coef(int idx, bit slewing);
        longint len, pos, num, n2, d2, q;
        if (!slewing)
            return longint'(cur_coefs[idx]);
        len = slew_total;
        pos = slew_pos;
        num = longint'(cur_coefs[idx]) * pos + longint'(prev_coefs[idx]) * (len - pos);
        n2  = 2 * num + len;
        d2  = 2 * len;
        q   = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0)
            q = q - 1;
        return q;
    endfunction

    function void take_item(mix_item_t it);
        longint      l, r, acc, y, smax, smin;
        bit          slewing;
        int          cnt, final_p;
        logic [3:0]  code;
        mix_result_t res;
        case (it.kind)
            smx_pkg::KIND_STAGE:
            begin
                if (it.coef_ch < MIX_CHANNELS)
                    staged_coefs[2 * it.coef_ch + it.coef_sd] = it.coef_val;
            end
            smx_pkg::KIND_COMMIT:
            begin
                for (int i = 0; i < MIX_BANK; i++)
                begin
                    prev_coefs[i] = cur_coefs[i];
                    cur_coefs[i]  = staged_coefs[i];
                end
                slew_total = it.slew_len;
                slew_pos   = '0;
            end
            smx_pkg::KIND_RESTORE:
            begin
                for (int i = 0; i < MIX_BANK; i++)
                    cur_coefs[i] = '0;
                if (it.chan_set <= smx_pkg::SET_LAST_DEFAULT)
                begin
                    cur_coefs[0] = MIX_COEF_BITS'(1 << MIX_FRAC);
                    cur_coefs[3] = MIX_COEF_BITS'(1 << MIX_FRAC);
                end
                slew_pos   = '0;
                slew_total = '0;
            end
            default:
            begin
                l       = longint'(it.l_smp);
                r       = longint'(it.r_smp);
                smax    = (longint'(1) <<< (MIX_SAMPLE_BITS - 1)) - 1;
                smin    = -smax - 1;
                slewing = (slew_total != 0) && (slew_pos < slew_total);
                cnt     = (chan_count > smx_pkg::MAP_POSITIONS) ? smx_pkg::MAP_POSITIONS
                                                                : int'(chan_count);
                final_p = -1;
                for (int p = 0; p < cnt; p++)
                begin
                    code = chan_map[4*p +: 4];
                    if (code != smx_pkg::CODE_UNKNOWN && code < MIX_CHANNELS)
                        final_p = p;
                end
                for (int p = 0; p < cnt; p++)
                begin
                    code = chan_map[4*p +: 4];
                    if (code == smx_pkg::CODE_UNKNOWN || code >= MIX_CHANNELS)
                        continue;
                    acc = l * blend_coef(2 * code, slewing)
                        + r * blend_coef(2 * code + 1, slewing);
                    y = (acc + (longint'(1) <<< (MIX_FRAC - 1))) >>> MIX_FRAC;
                    res.clipped = 1'b0;
                    if (y > smax)
                    begin
                        y = smax;
                        res.clipped = 1'b1;
                    end
                    if (y < smin)
                    begin
                        y = smin;
                        res.clipped = 1'b1;
                    end
                    res.position     = 3'(p);
                    res.contribution = y[MIX_SAMPLE_BITS-1:0];
                    res.last         = (p == final_p);
                    expected_mixes.push_back(res);
                end
                if (slewing)
                    slew_pos = slew_pos + 1'b1;
            end
        endcase
    endfunction

    function void check_output(mix_result_t got);
        mix_result_t exp_r;
        if (expected_mixes.size() == 0)
        begin
            $error("unexpected result at position %0d, contribution %0d",
                   got.position, got.contribution);
            errors++;
            return;
        end
        exp_r = expected_mixes.pop_front();
        if (got.position !== exp_r.position)
        begin
            $error("position: expected %0d, got %0d", exp_r.position, got.position);
            errors++;
        end
        if (got.contribution !== exp_r.contribution)
        begin
            $error("contribution: expected %0d, got %0d", exp_r.contribution,
                   got.contribution);
            errors++;
        end
        if (got.clipped !== exp_r.clipped)
        begin
            $error("clipped: expected %0d, got %0d", exp_r.clipped, got.clipped);
            errors++;
        end
        if (got.last !== exp_r.last)
        begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_mixes.size();
    endfunction
endclass

module tb_stereo_matrix_mixer_with_slew_top;

    localparam int CYCLE_LIMIT = 1000000;
    // settle margin covers a frame with every position skipped
    localparam int SETTLE_CYCLES = 24;
    localparam longint SMP_MAX = (longint'(1) <<< (MIX_SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;
    localparam longint CF_MAX  = (longint'(1) <<< (MIX_COEF_BITS - 1)) - 1;
    localparam longint CF_MIN  = -CF_MAX - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic                              cfg_index = 1'b0;
    logic [smx_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [smx_pkg::KIND_W-1:0]        kind = '0;
    logic signed [MIX_SAMPLE_BITS-1:0] left_sample = '0;
    logic signed [MIX_SAMPLE_BITS-1:0] right_sample = '0;
    logic [smx_pkg::CHAN_W-1:0]        coef_channel = '0;
    logic                              coef_side = 1'b0;
    logic signed [MIX_COEF_BITS-1:0]   coef_value = '0;
    logic [smx_pkg::SLEW_W-1:0]        slew_frames = '0;
    logic [smx_pkg::SET_W-1:0]         channel_set = '0;

    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [smx_pkg::POS_W-1:0]         position;
    logic signed [MIX_SAMPLE_BITS-1:0] contribution;
    logic                              clipped;
    logic                              last;

    mix_scoreboard sb;
    int            cycles = 0;
    // when set, neither side idles: a long stretch of back-to-back traffic
    bit            steady = 1'b0;

    stereo_matrix_mixer_with_slew_top #(
        .NUM_CHANNELS (MIX_CHANNELS),
        .SAMPLE_BITS  (MIX_SAMPLE_BITS),
        .COEF_BITS    (MIX_COEF_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .coef_channel (coef_channel),
        .coef_side    (coef_side),
        .coef_value   (coef_value),
        .slew_frames  (slew_frames),
        .channel_set  (channel_set),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .contribution (contribution),
        .clipped      (clipped),
        .last         (last)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver backpressure, decided at the falling edge
    always @(negedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 13);
    end

    // every accepted result transaction goes to the scoreboard
    always @(posedge clk)
    begin
        mix_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.position     = position;
            got.contribution = contribution;
            got.clipped      = clipped;
            got.last         = last;
            sb.check_output(got);
        end
    end

    // sample values: rails, small values near zero, and full-range noise
    function automatic logic signed [MIX_SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return SMP_MAX[MIX_SAMPLE_BITS-1:0];
        else if (roll < 20)
            return SMP_MIN[MIX_SAMPLE_BITS-1:0];
        else if (roll < 30)
            return MIX_SAMPLE_BITS'($signed($urandom_range(511)) - 256);
        return MIX_SAMPLE_BITS'($urandom());
    endfunction

    // mostly valid speakers, with unknown and out-of-range codes mixed in
    function automatic logic [smx_pkg::MAP_W-1:0] pick_map();
        logic [smx_pkg::MAP_W-1:0] m;
        int                        roll;
        for (int p = 0; p < smx_pkg::MAP_POSITIONS; p++)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                m[4*p +: 4] = 4'($urandom_range(MIX_CHANNELS - 1));
            else if (roll < 85)
                m[4*p +: 4] = smx_pkg::CODE_UNKNOWN;
            else
                m[4*p +: 4] = 4'($urandom_range(14, MIX_CHANNELS));
        end
        return m;
    endfunction

    function automatic mix_item_t pick_item();
        mix_item_t it;
        int        roll;
        it.l_smp    = pick_sample();
        it.r_smp    = pick_sample();
        it.coef_ch  = smx_pkg::CHAN_W'($urandom());
        it.coef_sd  = 1'($urandom());
        roll        = $urandom_range(99);
        if (roll < 8)
            it.coef_val = CF_MAX[MIX_COEF_BITS-1:0];
        else if (roll < 16)
            it.coef_val = CF_MIN[MIX_COEF_BITS-1:0];
        else
            it.coef_val = MIX_COEF_BITS'($urandom());
        // short crossfades finish inside a phase, the odd long one does not
        roll = $urandom_range(99);
        if (roll < 30)
            it.slew_len = '0;
        else if (roll < 85)
            it.slew_len = smx_pkg::SLEW_W'($urandom_range(12, 1));
        else if (roll < 97)
            it.slew_len = smx_pkg::SLEW_W'($urandom_range(200, 13));
        else
            it.slew_len = smx_pkg::SLEW_W'($urandom());
        it.chan_set = smx_pkg::SET_W'($urandom());
        roll = $urandom_range(99);
        if (roll < 65)
            it.kind = smx_pkg::KIND_FRAME;
        else if (roll < 85)
            it.kind = smx_pkg::KIND_STAGE;
        else if (roll < 95)
            it.kind = smx_pkg::KIND_COMMIT;
        else
            it.kind = smx_pkg::KIND_RESTORE;
        return it;
    endfunction

    function automatic mix_item_t blank_item(smx_pkg::kind_t k);
        mix_item_t it;
        it.kind     = k;
        it.l_smp    = '0;
        it.r_smp    = '0;
        it.coef_ch  = '0;
        it.coef_sd  = 1'b0;
        it.coef_val = '0;
        it.slew_len = '0;
        it.chan_set = '0;
        return it;
    endfunction

    function automatic mix_item_t frame_of(longint l, longint r);
        mix_item_t it;
        it       = blank_item(smx_pkg::KIND_FRAME);
        it.l_smp = l[MIX_SAMPLE_BITS-1:0];
        it.r_smp = r[MIX_SAMPLE_BITS-1:0];
        return it;
    endfunction

    function automatic mix_item_t stage_of(int ch, bit sd, longint v);
        mix_item_t it;
        it          = blank_item(smx_pkg::KIND_STAGE);
        it.coef_ch  = smx_pkg::CHAN_W'(ch);
        it.coef_sd  = sd;
        it.coef_val = v[MIX_COEF_BITS-1:0];
        return it;
    endfunction

    function automatic mix_item_t commit_of(int n);
        mix_item_t it;
        it          = blank_item(smx_pkg::KIND_COMMIT);
        it.slew_len = smx_pkg::SLEW_W'(n);
        return it;
    endfunction

    function automatic mix_item_t restore_of(int s);
        mix_item_t it;
        it          = blank_item(smx_pkg::KIND_RESTORE);
        it.chan_set = smx_pkg::SET_W'(s);
        return it;
    endfunction

    // one input transaction; random gaps are taken before valid goes high
    task automatic send_item(mix_item_t it);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind         <= it.kind;
        left_sample  <= it.l_smp;
        right_sample <= it.r_smp;
        coef_channel <= it.coef_ch;
        coef_side    <= it.coef_sd;
        coef_value   <= it.coef_val;
        slew_frames  <= it.slew_len;
        channel_set  <= it.chan_set;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_item(it);
    endtask

    task automatic write_reg(smx_pkg::cfg_index_t idx, logic [smx_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait out all expected results plus a frame that mixes nothing
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new register setting, then a run of random traffic
    task automatic run_phase(int count, logic [smx_pkg::MAP_W-1:0] map, int n_items, bit quiet);
        logic [smx_pkg::CFG_DATA_W-1:0] count_word;
        settle();
        // upper bits of the count write carry noise, only the low nibble counts
        count_word = $urandom();
        count_word[smx_pkg::COUNT_W-1:0] = smx_pkg::COUNT_W'(count);
        write_reg(smx_pkg::CFG_CHANNEL_COUNT, count_word);
        write_reg(smx_pkg::CFG_CHANNEL_MAP, map);
        steady = quiet;
        repeat (n_items) send_item(pick_item());
        steady = 1'b0;
    endtask

    initial
    begin
        sb = new;
        sb.reset_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: default pass-through bank with full-scale samples
        send_item(frame_of(SMP_MAX, SMP_MIN));
        send_item(frame_of(SMP_MIN, SMP_MAX));
        send_item(frame_of(0, 0));
        // coefficient extremes staged and committed without a slew
        send_item(stage_of(0, 1'b0, CF_MIN));
        send_item(stage_of(0, 1'b1, CF_MAX));
        send_item(stage_of(1, 1'b0, CF_MAX));
        send_item(stage_of(7, 1'b1, CF_MIN));
        send_item(commit_of(0));
        // gains near 2.0 push the sum past the rails
        send_item(frame_of(SMP_MAX, SMP_MAX));
        send_item(frame_of(SMP_MIN, SMP_MIN));
        send_item(frame_of(SMP_MIN, SMP_MAX));
        // longest crossfade, committed over the same bank
        send_item(commit_of(65535));
        send_item(frame_of(SMP_MAX, SMP_MIN));
        // a channel set beyond 7.1 restores an all-zero bank
        send_item(restore_of(4));
        send_item(frame_of(SMP_MAX, SMP_MAX));
        send_item(restore_of(3));
        // short crossfade runs to its end and beyond
        send_item(commit_of(3));
        send_item(frame_of(SMP_MAX, SMP_MIN));
        send_item(frame_of(SMP_MIN, SMP_MAX));
        send_item(frame_of(SMP_MAX, SMP_MAX));
        send_item(frame_of(SMP_MIN, SMP_MIN));
        send_item(restore_of(7));
        send_item(frame_of(SMP_MAX, SMP_MIN));
        send_item(restore_of(0));
        send_item(frame_of(12345, -54321));

        // random traffic over several map settings
        run_phase(8, 32'h7654_3210, 35, 1'b0);
        // no positions at all
        run_phase(0, pick_map(), 25, 1'b0);
        // count above eight acts as eight, map with skipped codes
        run_phase(15, 32'hF8E9_4F21, 35, 1'b0);
        // back-to-back stretch with no idling on either side
        run_phase($urandom_range(8, 1), pick_map(), 40, 1'b1);
        // every position unknown: frames only advance the slew
        run_phase(8, 32'hFFFF_FFFF, 20, 1'b0);
        // every position on speaker 0
        run_phase(8, 32'h0000_0000, 35, 1'b0);
        run_phase(1, $urandom(), 25, 1'b0);
        run_phase($urandom_range(15), pick_map(), 35, 1'b0);
        run_phase(8, pick_map(), 35, 1'b0);

        settle();
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/smx_pkg.sv
hw/rtl/smx_coef_bank.sv
hw/rtl/smx_mac_unit.sv
hw/rtl/stereo_matrix_mixer_with_slew_top.sv
sim/tb_stereo_matrix_mixer_with_slew_top.sv
